// ===== hw/rtl/pinball_io_write_decoder_core_defines.svh =====
// Assertion macros shared by the pinball output-board decoder RTL.
`ifndef PINBALL_IO_WRITE_DECODER_CORE_DEFINES_SVH
`define PINBALL_IO_WRITE_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pinball decoder assertion failed");

`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("pinball decoder sequence assertion failed");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== hw/rtl/pbwd_pkg.sv =====
// Package with payload types, address map and lookup functions of the pinball output decoder.
package pbwd_pkg;

    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] solenoid_word;
        logic        lamp_valid;
        logic [3:0]  lamp_index;
        logic [7:0]  lamp_data;
        logic        segment_valid;
        logic [5:0]  segment_index;
        logic [7:0]  segment_value;
        logic [7:0]  switch_column;
        logic        bank_flag;
    } t_out_item;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic VARIANT_FIRST  = 1'b0;
    localparam logic VARIANT_SECOND = 1'b1;

    localparam logic [15:0] ADDR_SOL_HIGH   = 16'h9000;
    localparam logic [15:0] ADDR_DISP_COL   = 16'h9002;
    localparam logic [15:0] ADDR_SWITCH_COL = 16'h9003;
    localparam logic [15:0] ADDR_SOL_16     = 16'h9006;
    localparam logic [15:0] ADDR_SOL_17     = 16'h9007;
    localparam logic [15:0] ADDR_SOL_BASE   = 16'hA008;
    localparam logic [15:0] ADDR_LAMP_BASE  = 16'hA010;
    localparam logic [15:0] ADDR_DISP_DATA  = 16'hA018;

    localparam logic [31:0] SOL_HIGH_KEEP  = 32'h000B_FFFF;
    localparam logic [31:0] SOL_16_KEEP    = 32'hFFFE_FFFF;
    localparam logic [31:0] SOL_17_KEEP    = 32'hFFFD_FFFF;
    localparam logic [31:0] SOL_LANE_MASK  = 32'h0100_0101;
    localparam logic [7:0]  SEG_DATA_MASK  = 8'h7F;
    localparam logic [5:0]  DISP_COUNT_MAX = 6'd63;
    localparam logic [5:0]  DISP_COUNT_END = 6'd47;

    function automatic logic [4:0] bit_pos_sum(input logic [7:0] x);
        logic [4:0] sum;
        sum = 5'd0;
        for (int i = 0; i < 8; i++) begin
            if (x[3'(i)]) begin
                sum = sum + 5'(i);
            end
        end
        return sum;
    endfunction

    function automatic logic [2:0] col_lookup(input logic [4:0] n);
        logic [2:0] col;
        case (n)
            5'd1:    col = 3'd5;
            5'd2:    col = 3'd4;
            5'd3:    col = 3'd3;
            5'd4:    col = 3'd0;
            5'd5:    col = 3'd6;
            5'd6:    col = 3'd1;
            5'd7:    col = 3'd2;
            default: col = 3'd0;
        endcase
        return col;
    endfunction

    function automatic logic [31:0] lamp_keep(input logic [2:0] k);
        logic [31:0] keep;
        case (k)
            3'd0:    keep = 32'h000F_FEFE;
            3'd1:    keep = 32'h000F_FDFD;
            3'd2:    keep = 32'h000F_FBFB;
            3'd3:    keep = 32'h000F_F7F7;
            3'd4:    keep = 32'h000F_EFFF;
            3'd5:    keep = 32'h000F_DFFF;
            3'd6:    keep = 32'h000F_BFFF;
            default: keep = 32'h000F_7F7F;
        endcase
        return keep;
    endfunction

    function automatic logic [5:0] seg_base(input logic variant, input logic [2:0] slot);
        logic [5:0] base;
        case (slot)
            3'd0:    base = (variant == VARIANT_SECOND) ? 6'd6  : 6'd20;
            3'd1:    base = (variant == VARIANT_SECOND) ? 6'd13 : 6'd27;
            3'd2:    base = (variant == VARIANT_SECOND) ? 6'd20 : 6'd6;
            3'd3:    base = (variant == VARIANT_SECOND) ? 6'd27 : 6'd13;
            3'd4:    base = 6'd34;
            3'd5:    base = 6'd41;
            default: base = 6'd0;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] permute_bits(input logic [7:0] x);
        return {x[0], x[6], x[2], x[1], x[4], x[5], x[7], x[3]};
    endfunction

endpackage

// ===== hw/rtl/pinball_io_write_decoder_core.sv =====
// Top level of the pinball output-board write decoder.
// Each accepted transfer is either a bus write or a zero-cross tick and yields exactly one
// result transfer with the solenoid word, the selected switch column, the lamp bank flag
// and, where the write causes them, one lamp column write or one display digit write.
// An item is captured in an input register and decoded into a result register, so one item
// is taken every cycle while the output does not stall; an output stall backs up into
// the input register and then into the input stall. The board wiring register is written
// through the configuration channel, which is always ready and must only be used while idle.
`include "pinball_io_write_decoder_core_defines.svh"

module pinball_io_write_decoder_core
    import pbwd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic        r_variant;
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        r_phase;
    logic        r_bank;
    logic [2:0]  r_dcol;
    logic [5:0]  r_dcnt;
    logic [7:0]  r_sel;
    logic [31:0] r_sol;

    logic        n_phase;
    logic        n_bank;
    logic [2:0]  n_dcol;
    logic [5:0]  n_dcnt;
    logic [7:0]  n_sel;
    logic [31:0] n_sol;
    t_out_item   n_out;

    logic        advance;
    logic [2:0]  k;
    logic [4:0]  pos_sum;
    logic [5:0]  base;
    logic [31:0] lamp_bits;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign k       = r_in.address[2:0];
    assign pos_sum = bit_pos_sum(r_in.data);
    assign base    = seg_base(r_variant, r_dcnt[5:3]);

    always_comb begin
        n_phase   = r_phase;
        n_bank    = r_bank;
        n_dcol    = r_dcol;
        n_dcnt    = r_dcnt;
        n_sel     = r_sel;
        n_sol     = r_sol;
        lamp_bits = 32'd0;
        n_out     = '0;

        if (r_in.op == OP_TICK) begin
            if (r_phase) begin
                n_bank = !r_bank;
            end
            n_phase = !r_phase;
        end else if (r_in.address[15:3] == ADDR_SOL_BASE[15:3]) begin
            if (r_variant == VARIANT_FIRST) begin
                if (pos_sum >= 5'd1 && pos_sum <= 5'd7) begin
                    n_dcol = col_lookup(pos_sum);
                end
                n_dcnt = 6'd0;
            end else begin
                n_sol = (r_sol & ~(SOL_LANE_MASK << k))
                      | (32'(r_in.data[0]) << k)
                      | ((32'(r_in.data[1]) << 8) << k)
                      | ((32'(r_in.data[3]) << 24) << k);
            end
        end else if (r_in.address[15:3] == ADDR_LAMP_BASE[15:3]) begin
            n_out.lamp_valid = 1'b1;
            n_out.lamp_index = {!r_bank, k};
            n_out.lamp_data  = r_in.data;
            if (r_variant == VARIANT_FIRST) begin
                lamp_bits = (32'(r_in.data[5]) << 8) << k;
                if (k <= 3'd3 || k == 3'd7) begin
                    lamp_bits = lamp_bits | (32'(r_in.data[3]) << k);
                end
                n_sol = (r_sol & lamp_keep(k)) | lamp_bits;
            end
        end else begin
            unique case (r_in.address)
                ADDR_SOL_HIGH: begin
                    if (r_variant == VARIANT_FIRST) begin
                        n_sol = (r_sol & SOL_HIGH_KEEP) | (32'(r_in.data[0]) << 18);
                    end
                end
                ADDR_DISP_COL: begin
                    n_dcol = {r_in.data[0], r_in.data[7:6]};
                    n_dcnt = 6'd0;
                end
                ADDR_SWITCH_COL: begin
                    n_sel = r_in.data;
                end
                ADDR_SOL_16: begin
                    n_sol = (r_sol & SOL_16_KEEP) | (32'(r_in.data[0]) << 16);
                end
                ADDR_SOL_17: begin
                    n_sol = (r_sol & SOL_17_KEEP) | (32'(r_in.data[0]) << 17);
                end
                ADDR_DISP_DATA: begin
                    if (r_dcnt[2:0] == 3'd7 && r_dcnt <= DISP_COUNT_END
                            && base >= {3'd0, r_dcol}) begin
                        n_out.segment_valid = 1'b1;
                        n_out.segment_index = base - {3'd0, r_dcol};
                        n_out.segment_value = (r_variant == VARIANT_SECOND)
                                            ? (r_in.data & SEG_DATA_MASK)
                                            : permute_bits(~r_in.data);
                    end
                    if (r_dcnt != DISP_COUNT_MAX) begin
                        n_dcnt = r_dcnt + 6'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        n_out.solenoid_word = n_sol;
        n_out.switch_column = n_sel;
        n_out.bank_flag     = n_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant   <= VARIANT_FIRST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_bank      <= 1'b0;
            r_dcol      <= 3'd0;
            r_dcnt      <= 6'd0;
            r_sel       <= 8'd0;
            r_sol       <= 32'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_variant <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_bank      <= n_bank;
                r_dcol      <= n_dcol;
                r_dcnt      <= n_dcnt;
                r_sel       <= n_sel;
                r_sol       <= n_sol;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLK(a_one_write_kind, r_out_valid |-> !(r_out.lamp_valid && r_out.segment_valid))
    `ASSERT_CLK(a_digit_range, (r_out_valid && r_out.segment_valid) |-> (r_out.segment_index <= 6'd41))
    `ASSERT_NEXT(a_tick_phase, advance && (r_in.op == OP_TICK), r_phase != $past(r_phase))
    `ASSERT_NEXT(a_held_item, r_in_valid && !advance, r_in_valid && $stable(r_in))

endmodule

// ===== test/pinball_io_write_decoder_core_chk.sv =====
// Checker that predicts every result transfer of the pinball output decoder and compares it.
`timescale 1ns / 100ps

module pinball_io_write_decoder_core_chk
    import pbwd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out,
    output int        o_pending,
    output int        o_mismatches
);

    // Digit bases per eight-write slot, and the column picked by a bit position sum.
    localparam logic [5:0][5:0] DIGIT_BASE_FIRST  = {6'd41, 6'd34, 6'd13, 6'd6, 6'd27, 6'd20};
    localparam logic [5:0][5:0] DIGIT_BASE_SECOND = {6'd41, 6'd34, 6'd27, 6'd20, 6'd13, 6'd6};
    localparam logic [6:0][2:0] COLUMN_BY_SUM     = {3'd2, 3'd1, 3'd6, 3'd0, 3'd3, 3'd4, 3'd5};
    // Source bit of the inverted data for each segment bit on the first wiring.
    localparam logic [7:0][2:0] SEGMENT_SOURCE    = {3'd0, 3'd6, 3'd2, 3'd1,
                                                     3'd4, 3'd5, 3'd7, 3'd3};

    logic        wiring;
    logic        tick_phase;
    logic        lamp_bank;
    logic [2:0]  display_col;
    logic [5:0]  display_count;
    logic [7:0]  switch_col;
    logic [31:0] solenoid_bits;
    t_out_item   expected_results[$];
    int          mismatch_total;

    function automatic t_out_item decode_item(input t_in_item it);
        t_out_item   r;
        logic [2:0]  k;
        logic [31:0] low_bit;
        logic [31:0] keep;
        logic [7:0]  inverted;
        int          pos_sum;
        int          digit;
        r = '0;
        k = it.address[2:0];
        if (it.op == OP_TICK) begin
            if (tick_phase) begin
                lamp_bank = ~lamp_bank;
            end
            tick_phase = ~tick_phase;
        end else if (it.address == ADDR_SOL_HIGH) begin
            if (wiring == VARIANT_FIRST) begin
                solenoid_bits = (solenoid_bits & SOL_HIGH_KEEP) | (32'(it.data[0]) << 18);
            end
        end else if (it.address == ADDR_DISP_COL) begin
            display_col = {it.data[0], it.data[7:6]};
            display_count = '0;
        end else if (it.address == ADDR_SWITCH_COL) begin
            switch_col = it.data;
        end else if (it.address == ADDR_SOL_16) begin
            solenoid_bits = (solenoid_bits & SOL_16_KEEP) | (32'(it.data[0]) << 16);
        end else if (it.address == ADDR_SOL_17) begin
            solenoid_bits = (solenoid_bits & SOL_17_KEEP) | (32'(it.data[0]) << 17);
        end else if (it.address[15:3] == ADDR_SOL_BASE[15:3]) begin
            if (wiring == VARIANT_FIRST) begin
                pos_sum = 0;
                for (int b = 0; b < 8; b++) begin
                    if (it.data[3'(b)]) begin
                        pos_sum += b;
                    end
                end
                if (pos_sum >= 1 && pos_sum <= 7) begin
                    display_col = COLUMN_BY_SUM[3'(pos_sum - 1)];
                end
                display_count = '0;
            end else begin
                solenoid_bits = (solenoid_bits & ~(SOL_LANE_MASK << k))
                              | (32'(it.data[0]) << k)
                              | (32'(it.data[1]) << (8 + k))
                              | (32'(it.data[3]) << (24 + k));
            end
        end else if (it.address[15:3] == ADDR_LAMP_BASE[15:3]) begin
            r.lamp_valid = 1'b1;
            r.lamp_index = {~lamp_bank, k};
            r.lamp_data = it.data;
            if (wiring == VARIANT_FIRST) begin
                if (k <= 3) begin
                    low_bit = 32'd1 << k;
                end else if (k == 7) begin
                    low_bit = 32'd1 << 7;
                end else begin
                    low_bit = '0;
                end
                keep = 32'h000F_FFFF & ~((32'd1 << (8 + k)) | low_bit);
                solenoid_bits = (solenoid_bits & keep) | (32'(it.data[5]) << (8 + k))
                              | (it.data[3] ? low_bit : 32'd0);
            end
        end else if (it.address == ADDR_DISP_DATA) begin
            if (display_count[2:0] == 3'b111 && display_count <= DISP_COUNT_END) begin
                if (wiring == VARIANT_SECOND) begin
                    digit = int'(DIGIT_BASE_SECOND[display_count[5:3]]) - int'(display_col);
                end else begin
                    digit = int'(DIGIT_BASE_FIRST[display_count[5:3]]) - int'(display_col);
                end
                if (digit >= 0) begin
                    r.segment_valid = 1'b1;
                    r.segment_index = 6'(digit);
                    if (wiring == VARIANT_SECOND) begin
                        r.segment_value = it.data & SEG_DATA_MASK;
                    end else begin
                        inverted = ~it.data;
                        for (int b = 0; b < 8; b++) begin
                            r.segment_value[3'(b)] = inverted[SEGMENT_SOURCE[3'(b)]];
                        end
                    end
                end
            end
            if (display_count != DISP_COUNT_MAX) begin
                display_count = display_count + 6'd1;
            end
        end
        r.solenoid_word = solenoid_bits;
        r.switch_column = switch_col;
        r.bank_flag = lamp_bank;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            wiring = VARIANT_FIRST;
            tick_phase = 1'b0;
            lamp_bank = 1'b0;
            display_col = '0;
            display_count = '0;
            switch_col = '0;
            solenoid_bits = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                wiring = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer arrived with no expected result waiting");
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("solenoid_word", want.solenoid_word, i_out.solenoid_word);
                    check_field("lamp_valid", 32'(want.lamp_valid), 32'(i_out.lamp_valid));
                    check_field("lamp_index", 32'(want.lamp_index), 32'(i_out.lamp_index));
                    check_field("lamp_data", 32'(want.lamp_data), 32'(i_out.lamp_data));
                    check_field("segment_valid", 32'(want.segment_valid),
                                32'(i_out.segment_valid));
                    check_field("segment_index", 32'(want.segment_index),
                                32'(i_out.segment_index));
                    check_field("segment_value", 32'(want.segment_value),
                                32'(i_out.segment_value));
                    check_field("switch_column", 32'(want.switch_column),
                                32'(i_out.switch_column));
                    check_field("bank_flag", 32'(want.bank_flag), 32'(i_out.bank_flag));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(decode_item(i_in));
            end
        end
        o_pending <= expected_results.size();
        o_mismatches <= mismatch_total;
    end

endmodule

// ===== test/pinball_io_write_decoder_core_tb.sv =====
// Top of the pinball output decoder testbench: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps

module pinball_io_write_decoder_core_tb
    import pbwd_pkg::*;
();

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam logic [15:0] ADDR_UNUSED_1 = ADDR_SOL_HIGH + 16'd1;
    localparam logic [15:0] ADDR_UNUSED_4 = ADDR_SOL_HIGH + 16'd4;
    localparam logic [15:0] ADDR_UNUSED_5 = ADDR_SOL_HIGH + 16'd5;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int pending;
    int mismatches;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int items_sent = 0;

    always #5 clk = ~clk;

    pinball_io_write_decoder_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    pinball_io_write_decoder_core_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always @(posedge clk) begin
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
        t_in_item it;
        it.op = OP_WRITE;
        it.address = addr;
        it.data = data;
        send_item(it);
    endtask

    task automatic send_tick();
        t_in_item it;
        it.op = OP_TICK;
        it.address = 16'($urandom);
        it.data = 8'($urandom);
        send_item(it);
    endtask

    task automatic write_wiring(input logic variant);
        cfg_valid <= 1'b1;
        cfg_data <= variant;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results(input int extra_cycles);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (extra_cycles) @(posedge clk);
    endtask

    task automatic run_directed(input logic variant);
        if (variant == VARIANT_FIRST) begin
            repeat (3) send_tick();
            send_write(ADDR_SOL_HIGH, 8'hFF);
            send_write(ADDR_SOL_16, 8'hFF);
            send_write(ADDR_SOL_17, 8'h01);
            send_write(ADDR_SOL_BASE, 8'hFF);
            send_write(ADDR_SOL_BASE + 16'd7, 8'h00);
            send_write(ADDR_SOL_BASE + 16'd3, 8'h0C);
            send_write(ADDR_LAMP_BASE, 8'hFF);
            send_write(ADDR_LAMP_BASE + 16'd7, 8'h28);
            send_write(ADDR_SWITCH_COL, 8'hFF);
            send_write(16'hFFFF, 8'hFF);
            send_write(ADDR_UNUSED_1, 8'h00);
        end else begin
            send_write(ADDR_SOL_HIGH, 8'hFF);
            send_write(ADDR_SOL_BASE, 8'hFF);
            send_write(ADDR_SOL_BASE + 16'd7, 8'h0B);
            send_write(ADDR_LAMP_BASE + 16'd4, 8'h28);
            // Column 7 pushes the first digit below zero, so its write is dropped.
            send_write(ADDR_DISP_COL, 8'hC1);
            repeat (8) send_write(ADDR_DISP_DATA, 8'($urandom));
        end
        items_sent += (variant == VARIANT_FIRST) ? 14 : 13;
    endtask

    task automatic run_random(input int quota, input logic variant);
        int         sent;
        int         pause_at;
        int         pick;
        int         burst;
        logic [2:0] k;
        sent = 0;
        pause_at = $urandom_range(quota - 1, 20);
        while (sent < quota) begin
            if (pause_at >= 0 && sent >= pause_at) begin
                wait_for_results(0);
                pause_at = -1;
            end
            pick = $urandom_range(99);
            k = 3'($urandom_range(7));
            if (pick < 30) begin
                // A display frame: column select followed by a run of data writes.
                if (variant == VARIANT_FIRST && $urandom_range(1) == 1) begin
                    send_write(ADDR_SOL_BASE + 16'(k), 8'($urandom));
                end else begin
                    send_write(ADDR_DISP_COL, 8'($urandom));
                end
                burst = ($urandom_range(7) == 0) ? $urandom_range(72, 64)
                                                 : $urandom_range(48, 6);
                repeat (burst) begin
                    if ($urandom_range(9) == 0) begin
                        send_tick();
                        sent++;
                    end
                    send_write(ADDR_DISP_DATA, 8'($urandom));
                end
                sent += burst + 1;
            end else if (pick < 45) begin
                send_tick();
                sent++;
            end else if (pick < 65) begin
                send_write(ADDR_LAMP_BASE + 16'(k), 8'($urandom));
                sent++;
            end else if (pick < 80) begin
                case ($urandom_range(3))
                    0: send_write(ADDR_SOL_HIGH, 8'($urandom));
                    1: send_write(ADDR_SOL_16, 8'($urandom));
                    2: send_write(ADDR_SOL_17, 8'($urandom));
                    default: send_write(ADDR_SOL_BASE + 16'(k), 8'($urandom));
                endcase
                sent++;
            end else if (pick < 88) begin
                send_write(ADDR_SWITCH_COL, 8'($urandom));
                sent++;
            end else if (pick < 94) begin
                case ($urandom_range(2))
                    0: send_write(ADDR_UNUSED_1, 8'($urandom));
                    1: send_write(ADDR_UNUSED_4, 8'($urandom));
                    default: send_write(ADDR_UNUSED_5, 8'($urandom));
                endcase
                sent++;
            end else begin
                send_write(16'($urandom), 8'($urandom));
                sent++;
            end
        end
        items_sent += sent;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct <= 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct <= 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            write_wiring(phase[0] ? VARIANT_SECOND : VARIANT_FIRST);
            if (phase < 2) begin
                run_directed(phase[0] ? VARIANT_SECOND : VARIANT_FIRST);
            end
            run_random(ITEMS_PER_PHASE, phase[0] ? VARIANT_SECOND : VARIANT_FIRST);
            wait_for_results(4);
        end
        $display("Ran %0d writes and ticks in %0d phases on both board wirings,", items_sent,
                 NUM_PHASES);
        $display("with sender gaps and receiver stalls in both ratios and at full rate.");
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
